@@ src/zrld_pkg.sv @@
// Package for the zero run-length decoder: field widths, sequencer state
// and the command/status structs between the sequencer and position unit.
// No dependencies.
`default_nettype none
package zrld_pkg;

  localparam int unsigned RUN_W  = 6;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned CFG_W  = 7;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } zrld_state_t;

  // command from sequencer to position unit
  typedef struct packed {
    logic norm;   // start of a pair: wrap position if it lies past the block
    logic step;   // one sample went out: advance or wrap
  } zrld_pos_cmd_t;

  // status from position unit to sequencer
  typedef struct packed {
    logic at_end; // current position is the last sample of the block
  } zrld_pos_stat_t;

endpackage : zrld_pkg
`default_nettype wire

@@ src/zrld_pos.sv @@
// Block position counter with its shared compare logic.
// Depends on zrld_pkg.
`default_nettype none
module zrld_pos
  import zrld_pkg::*;
#(
  parameter int unsigned LW = 7
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [LW-1:0]  len,
  input  zrld_pos_cmd_t       cmd,
  output zrld_pos_stat_t      stat
);

  logic [LW-1:0] pos;
  logic [LW-1:0] pos_next;
  logic [LW:0]   pos_inc;

  assign pos_inc     = {1'b0, pos} + {{LW{1'b0}}, 1'b1};
  assign stat.at_end = (pos_inc == {1'b0, len});

  always_comb begin
    pos_next = pos;
    if (cmd.norm) begin
      if (pos >= len) pos_next = '0;
    end else if (cmd.step) begin
      pos_next = stat.at_end ? '0 : pos_inc[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule : zrld_pos
`default_nettype wire

@@ src/zrld_ctrl.sv @@
// Sequencer: holds one pair, emits one sample per step, drives the
// position unit. Depends on zrld_pkg.
`default_nettype none
module zrld_ctrl
  import zrld_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [RUN_W-1:0]         zero_run,
  input  wire logic signed [COEF_W-1:0] coefficient,
  input  wire logic                     end_of_block,
  input  wire logic                     out_free,
  input  zrld_pos_stat_t                stat,
  output zrld_pos_cmd_t                 cmd,
  output logic                          ready,
  output logic                          emit,
  output logic signed [COEF_W-1:0]      sample,
  output logic                          last_of_item,
  output logic                          block_end,
  output logic                          overflow
);

  zrld_state_t               state;
  zrld_state_t               state_next;
  logic [RUN_W-1:0]          cnt;
  logic signed [COEF_W-1:0]  coef;
  logic                      eob;
  logic                      zero_phase;
  logic                      done;

  assign zero_phase = eob || (cnt != '0);
  assign done       = zero_phase ? stat.at_end : 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_RUN;
      ST_RUN:  if (emit && done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready        = 1'b0;
    emit         = 1'b0;
    sample       = '0;
    last_of_item = 1'b0;
    block_end    = 1'b0;
    overflow     = 1'b0;
    cmd.norm     = 1'b0;
    cmd.step     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ready    = 1'b1;
        cmd.norm = accept;
      end
      ST_RUN: begin
        emit         = out_free;
        cmd.step     = out_free;
        sample       = zero_phase ? '0 : coef;
        last_of_item = done;
        block_end    = stat.at_end;
        // a run that hits the block end drops the pair's value
        overflow     = zero_phase && stat.at_end && !eob;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt  <= zero_run;
      coef <= coefficient;
      eob  <= end_of_block;
    end else if (emit && zero_phase && (cnt != '0)) begin
      cnt <= cnt - {{(RUN_W-1){1'b0}}, 1'b1};
    end
  end

endmodule : zrld_ctrl
`default_nettype wire

@@ src/zero_run_length_decoder.sv @@
// Top level of the zero run-length decoder: config register, block length
// clamp, output register. Depends on zrld_pkg, zrld_pos, zrld_ctrl.
//
// channel   dir  bits  fields (low bit first)
// --------  ---  ----  -----------------------------------------------
// s_*       in   24+1  tdata: zero_run[5:0], coefficient[21:6], pad
//                      tuser: end_of_block
// m_*       out  16+3  tdata: sample; tlast: last_of_item
//                      tuser: block_end, overflow
// cfg_*     in   7     block_length, written when cfg_wen is high
//
// Flow: a pair gives run+1 samples (block remainder for end-of-block or
// a run that reaches the block end), one sample per cycle from the
// sequencer while m_* is not stalled, then idle takes the next pair.
// The output register lets the next sample form while the last one waits.
// Backpressure on m_* freezes the sequencer; s_tready is low while a pair
// is being expanded.
// Reset (rst, synchronous): block_length 64, position 0, channels empty.
`default_nettype none
module zero_run_length_decoder
  import zrld_pkg::*;
#(
  parameter int unsigned MAX_BLOCK = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // input pairs
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,   // zero_run, coefficient, zero pad
  input  wire logic [0:0]        s_tuser,   // end_of_block
  // decoded samples
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,   // sample
  output logic                   m_tlast,   // last_of_item
  output logic [1:0]             m_tuser,   // block_end, overflow
  // configuration
  input  wire logic              cfg_wen,
  input  wire logic [CFG_W-1:0]  cfg_wdata  // block_length
);

  localparam int unsigned LW = $clog2(MAX_BLOCK + 1);

  logic [CFG_W-1:0]          block_length;
  logic [LW-1:0]             len;
  logic                      accept;
  logic                      out_free;
  zrld_pos_cmd_t             cmd;
  zrld_pos_stat_t            stat;
  logic                      emit;
  logic signed [COEF_W-1:0]  sample;
  logic                      last_of_item;
  logic                      block_end;
  logic                      overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= CFG_W'(64);
    end else if (cfg_wen) begin
      block_length <= cfg_wdata;
    end
  end

  // effective length: block_length saturated to 1..MAX_BLOCK
  always_comb begin
    if (block_length == '0) begin
      len = LW'(1);
    end else if (32'(block_length) >= MAX_BLOCK) begin
      len = LW'(MAX_BLOCK);
    end else begin
      len = LW'(block_length);
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  zrld_pos #(
    .LW (LW)
  ) u_pos (
    .clk  (clk),
    .rst  (rst),
    .len  (len),
    .cmd  (cmd),
    .stat (stat)
  );

  zrld_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .zero_run     (s_tdata[5:0]),
    .coefficient  (s_tdata[21:6]),
    .end_of_block (s_tuser[0]),
    .out_free     (out_free),
    .stat         (stat),
    .cmd          (cmd),
    .ready        (s_tready),
    .emit         (emit),
    .sample       (sample),
    .last_of_item (last_of_item),
    .block_end    (block_end),
    .overflow     (overflow)
  );

  // output register: loads a new sample whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= sample;
      m_tlast <= last_of_item;
      m_tuser <= {overflow, block_end};
    end
  end

endmodule : zero_run_length_decoder
`default_nettype wire
